// ===== sv/tdlb_pkg.sv =====
// ----------------------------------------------------------------------------
// tdlb_pkg
// Types, constants and the segment table of the two-digit LED multiplexer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdlb_pkg;

  localparam int unsigned TIME_W     = 7;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [TIME_W-1:0] TIME_MAX      = 7'd99;
  localparam logic [SEG_W-1:0]  KEEP_MASK     = 8'h10;
  localparam logic [CNT_W-1:0]  BLINK_SECONDS = 3'd6;

  // divide by ten for values up to 99: (t * 205) >> 11
  localparam logic [7:0] DIV10_MUL   = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  typedef struct packed {
    logic              power_sense;
    logic              key_pressed;
    logic              tilt_disable;
    logic              blink_mode;
    logic              second_tick;
    logic [TIME_W-1:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic             clear_idle_count;
    logic             start_timer;
    logic             blink_done;
    logic             fan_on;
    logic             relay_on;
    logic             units_enable_n;
    logic             tens_enable_n;
    logic [SEG_W-1:0] segment_code;
  } result_t;

  typedef struct packed {
    logic             digit_phase;
    logic             display_lit;
    logic [CNT_W-1:0] blink_count;
    logic             relay_level;
    logic             fan_level;
    logic [SEG_W-1:0] held_segments;
  } state_t;

  function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 8'h80;
      4'd1:    code = 8'hE9;
      4'd2:    code = 8'h44;
      4'd3:    code = 8'h60;
      4'd4:    code = 8'h29;
      4'd5:    code = 8'h22;
      4'd6:    code = 8'h02;
      4'd7:    code = 8'hE8;
      4'd8:    code = 8'h00;
      4'd9:    code = 8'h20;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tdlb_step.sv =====
// ----------------------------------------------------------------------------
// tdlb_step
// One refresh tick: digit select, segment code, blink and start sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module tdlb_step (
  input  var tdlb_pkg::in_item_t item_i,
  input  var tdlb_pkg::state_t   state_i,
  output tdlb_pkg::state_t       state_o,
  output tdlb_pkg::result_t      result_o
);

  logic [tdlb_pkg::TIME_W-1:0]  t_sat;
  logic [14:0]                  prod;
  logic [tdlb_pkg::DIGIT_W-1:0] tens;
  logic [tdlb_pkg::DIGIT_W-1:0] units;
  logic [tdlb_pkg::DIGIT_W-1:0] digit;
  logic [tdlb_pkg::CNT_W-1:0]   cnt_inc;
  logic [tdlb_pkg::TIME_W-1:0]  tens_x10;
  logic                         phase_n;

  assign t_sat    = (item_i.time_value > tdlb_pkg::TIME_MAX) ? tdlb_pkg::TIME_MAX
                                                             : item_i.time_value;
  assign prod     = 15'(t_sat) * 15'(tdlb_pkg::DIV10_MUL);
  assign tens     = tdlb_pkg::DIGIT_W'(prod >> tdlb_pkg::DIV10_SHIFT);
  assign tens_x10 = tdlb_pkg::TIME_W'({tens, 3'b000}) + tdlb_pkg::TIME_W'({tens, 1'b0});
  assign units    = tdlb_pkg::DIGIT_W'(t_sat - tens_x10);
  assign phase_n  = ~state_i.digit_phase;
  assign digit    = phase_n ? tens : units;
  assign cnt_inc  = state_i.blink_count + 3'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.tens_enable_n  = 1'b1;
    result_o.units_enable_n = 1'b1;
    state_o.digit_phase = phase_n;

    if (state_i.display_lit) begin
      state_o.held_segments = (state_i.held_segments & tdlb_pkg::KEEP_MASK)
                              | tdlb_pkg::seg_lookup(digit);
      if (phase_n) begin
        result_o.tens_enable_n = 1'b0;
      end else begin
        result_o.units_enable_n = 1'b0;
      end
    end

    if (item_i.second_tick && item_i.blink_mode) begin
      state_o.display_lit = ~state_i.display_lit;
      if (!item_i.tilt_disable) begin
        if (item_i.key_pressed) begin
          state_o.display_lit       = 1'b1;
          result_o.clear_idle_count = 1'b1;
        end else if (t_sat != '0) begin
          if (cnt_inc == tdlb_pkg::BLINK_SECONDS) begin
            state_o.blink_count  = '0;
            state_o.display_lit  = 1'b1;
            result_o.blink_done  = 1'b1;
            result_o.start_timer = 1'b1;
            if (item_i.power_sense) begin
              state_o.relay_level = 1'b1;
              state_o.fan_level   = 1'b1;
            end
          end else begin
            state_o.blink_count = cnt_inc;
          end
        end
      end
    end

    if (item_i.tilt_disable || t_sat == '0) begin
      state_o.relay_level = 1'b0;
    end

    result_o.segment_code = state_o.held_segments;
    result_o.relay_on     = state_o.relay_level;
    result_o.fan_on       = state_o.fan_level;
  end

endmodule

`default_nettype wire

// ===== sv/two_digit_led_mux_with_blink_start.sv =====
// ----------------------------------------------------------------------------
// two_digit_led_mux_with_blink_start
// Two-digit seven-segment multiplexer with a blink-to-start sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat on the s_axis side is one display refresh tick carrying
//   the time value and the status flags (tick, blink, tilt, key, power).
//   Each beat yields exactly one output beat on m_axis: segment code, the
//   two active-low digit selects, relay and fan levels, and the
//   blink_done / start_timer / clear_idle_count pulses.
//   Path: input register, then result register, to the output beat.
//   Throughput: one beat per cycle while m_axis_tready is high, set by the
//   combinational step logic that reads and updates the display state.
//   Reset: all state (digit phase, lit flag, blink count, relay, fan, held
//   segments) clears to zero and both channels come up empty.
//   Stall: while a result waits and m_axis_tready is low, it holds; the input
//   register still takes one more beat, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module two_digit_led_mux_with_blink_start (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] time_value, [7] second_tick, [8] blink_mode, [9] tilt_disable,
  // [10] key_pressed, [11] power_sense, [15:12] unused
  input  wire  [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] segment_code, [8] tens_enable_n, [9] units_enable_n, [10] relay_on,
  // [11] fan_on, [12] blink_done, [13] start_timer, [14] clear_idle_count,
  // [15] zero
  output logic [15:0] m_axis_tdata
);

  tdlb_pkg::in_item_t in_q;
  logic               in_valid_q;
  tdlb_pkg::result_t  out_q;
  logic               out_valid_q;
  tdlb_pkg::state_t   state_q;
  tdlb_pkg::state_t   state_d;
  tdlb_pkg::result_t  result_d;
  logic               advance;
  logic               s_take;

  // stage moves when it holds a beat and the result slot is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  tdlb_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_q <= tdlb_pkg::in_item_t'(s_axis_tdata[11:0]);
    end
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

  // never both digits selected at once
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.tens_enable_n || out_q.units_enable_n))
    else $error("both digit selects active");

  // end of blink sequence always starts the timer
  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.blink_done == out_q.start_timer))
    else $error("blink_done and start_timer disagree");

  // relay only ever switched on together with the fan
  a_relay_fan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.relay_level |-> state_q.fan_level)
    else $error("relay on without fan");

  // a dark display yields a result with both selects off
  a_dark_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !state_q.display_lit) |=>
      (out_q.tens_enable_n && out_q.units_enable_n))
    else $error("digit selected while display blanked");

  // key clear and blink completion are exclusive
  a_key_vs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.clear_idle_count && out_q.blink_done))
    else $error("key clear and blink done together");

endmodule

`default_nettype wire
